@@ hdl/trial_division_prime_test_defines.svh @@
// Assertion macros shared by the trial division prime test RTL.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH
`define TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define TDPT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define TDPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define TDPT_ASSERT_NOW(lbl, ante, cons, msg)

`define TDPT_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ hdl/tdpt_pkg.sv @@
// Shared types and constants for the trial division prime test.
// No dependencies.
`default_nettype none

package tdpt_pkg;

  localparam int CLS_W = 2;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [CLS_W-1:0] {
    CLS_NOT_PRIME = 2'd0,
    CLS_PRIME     = 2'd1,
    CLS_TRIAL     = 2'd2
  } cls_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

`default_nettype wire

@@ hdl/tdpt_front.sv @@
// Front end: accepts numbers and classifies them before queueing.
// Depends on tdpt_pkg.
`default_nettype none

module tdpt_front #(
  parameter int W = 31
) (
  input  wire logic                        start,
  input  wire logic [W-1:0]                in_number,
  input  wire tdpt_pkg::qstat_t            qstat,
  output logic                             busy,
  output logic                             push,
  output logic [W+tdpt_pkg::CLS_W-1:0]     entry
);

  tdpt_pkg::cls_t cls;

  always_comb begin
    priority if ((in_number >> 1) == '0) begin
      cls = tdpt_pkg::CLS_NOT_PRIME;
    end else if ((in_number >> 2) == '0) begin
      cls = tdpt_pkg::CLS_PRIME;
    end else if (!in_number[0]) begin
      cls = tdpt_pkg::CLS_NOT_PRIME;
    end else begin
      cls = tdpt_pkg::CLS_TRIAL;
    end
  end

  assign busy  = qstat.full;
  assign push  = start && !qstat.full;
  assign entry = {cls, in_number};

endmodule

`default_nettype wire

@@ hdl/tdpt_queue.sv @@
// Short FIFO between the classifying front end and the divider back end.
// Depends on tdpt_pkg.
`default_nettype none

module tdpt_queue #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rd_data,
  output tdpt_pkg::qstat_t      qstat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign qstat.full  = (cnt_r == CNT_W'(DEPTH));
  assign qstat.empty = (cnt_r == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign rd_data     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

@@ hdl/tdpt_back.sv @@
// Back end: runs trial division with a bit-serial remainder unit.
// Depends on tdpt_pkg and trial_division_prime_test_defines.svh.
`default_nettype none
`include "trial_division_prime_test_defines.svh"

module tdpt_back #(
  parameter int W = 31
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [W+tdpt_pkg::CLS_W-1:0] entry,
  input  wire tdpt_pkg::qstat_t             qstat,
  output logic                              pop,
  output logic                              out_valid,
  output logic                              out_is_prime,
  output logic [W-1:0]                      out_tested_number
);

  localparam int CNT_W = (W > 1) ? $clog2(W) : 1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_DIV   = 3'b010,
    ST_CHECK = 3'b100
  } state_t;

  state_t         state_r, state_nxt;
  logic [W-1:0]   n_r, n_nxt;
  logic [W-1:0]   div_r, div_nxt;
  logic [W-1:0]   quo_r, quo_nxt;
  logic [W-1:0]   rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic           valid_r, valid_nxt;
  logic           prime_r, prime_nxt;
  logic [W-1:0]   num_out_r, num_out_nxt;

  tdpt_pkg::cls_t cls;
  logic [W-1:0]   q_num;
  logic [W:0]     rem_sh;
  logic           ge;

  assign cls    = tdpt_pkg::cls_t'(entry[W+tdpt_pkg::CLS_W-1:W]);
  assign q_num  = entry[W-1:0];
  assign rem_sh = {rem_r, quo_r[W-1]};
  assign ge     = (rem_sh >= {1'b0, div_r});
  assign pop    = (state_r == ST_IDLE) && !qstat.empty;

  always_comb begin
    state_nxt   = state_r;
    n_nxt       = n_r;
    div_nxt     = div_r;
    quo_nxt     = quo_r;
    rem_nxt     = rem_r;
    cnt_nxt     = cnt_r;
    valid_nxt   = 1'b0;
    prime_nxt   = prime_r;
    num_out_nxt = num_out_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!qstat.empty) begin
          if (cls == tdpt_pkg::CLS_TRIAL) begin
            n_nxt     = q_num;
            div_nxt   = W'(3);
            quo_nxt   = q_num;
            rem_nxt   = '0;
            cnt_nxt   = CNT_W'(W - 1);
            state_nxt = ST_DIV;
          end else begin
            valid_nxt   = 1'b1;
            prime_nxt   = (cls == tdpt_pkg::CLS_PRIME);
            num_out_nxt = q_num;
          end
        end
      end
      ST_DIV: begin
        rem_nxt = ge ? W'(rem_sh - {1'b0, div_r}) : W'(rem_sh);
        quo_nxt = {quo_r[W-2:0], ge};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        priority if (div_r > quo_r) begin
          valid_nxt   = 1'b1;
          prime_nxt   = 1'b1;
          num_out_nxt = n_r;
          state_nxt   = ST_IDLE;
        end else if (rem_r == '0) begin
          valid_nxt   = 1'b1;
          prime_nxt   = 1'b0;
          num_out_nxt = n_r;
          state_nxt   = ST_IDLE;
        end else begin
          div_nxt   = div_r + W'(2);
          quo_nxt   = n_r;
          rem_nxt   = '0;
          cnt_nxt   = CNT_W'(W - 1);
          state_nxt = ST_DIV;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r       <= n_nxt;
    div_r     <= div_nxt;
    quo_r     <= quo_nxt;
    rem_r     <= rem_nxt;
    cnt_r     <= cnt_nxt;
    prime_r   <= prime_nxt;
    num_out_r <= num_out_nxt;
  end

  assign out_valid         = valid_r;
  assign out_is_prime      = prime_r;
  assign out_tested_number = num_out_r;

  `TDPT_ASSERT_NOW(a_div_odd, state_r == ST_DIV, div_r[0] && (div_r >= W'(3)), "even or small divisor")
  `TDPT_ASSERT_NOW(a_prime_ge2, valid_r && prime_r, (num_out_r >> 1) != '0, "0 or 1 flagged prime")
  `TDPT_ASSERT_NEXT(a_trial_no_out, (state_r == ST_IDLE) && !qstat.empty && (cls == tdpt_pkg::CLS_TRIAL), !valid_r && (state_r == ST_DIV), "trial item not started")
  `TDPT_ASSERT_NEXT(a_check_exit, (state_r == ST_CHECK) && valid_nxt, state_r == ST_IDLE, "check did not return idle")

endmodule

`default_nettype wire

@@ hdl/trial_division_prime_test.sv @@
// Top level of the trial division prime test.
// Depends on tdpt_pkg, tdpt_front, tdpt_queue and tdpt_back.
//
// Usage: raise start with in_number; the number is taken at a rising edge with
// start high and busy low. busy is high while the two-entry queue is full.
// Each number yields one result: out_valid is high for exactly one cycle with
// out_is_prime and out_tested_number. The receiver cannot stall.
// Numbers 0 to 3 and even numbers are settled by the front end; the queue
// holds the class and the back end reports it through its output registers
// when it is free. Odd numbers from 5 are tried against odd divisors
// 3, 5, 7, ... while divisor <= number / divisor; each trial runs the
// bit-serial remainder unit and then checks the quotient and remainder.
// Items are served in order. Reset empties the queue and idles the back end;
// no result is lost otherwise.
`default_nettype none

module trial_division_prime_test #(
  parameter int NUMBER_WIDTH = 31
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [NUMBER_WIDTH-1:0] in_number,
  output logic                         out_valid,
  output logic                         out_is_prime,
  output logic [NUMBER_WIDTH-1:0]      out_tested_number
);

  localparam int ENTRY_W = NUMBER_WIDTH + tdpt_pkg::CLS_W;

  tdpt_pkg::qstat_t   qstat;
  logic               push;
  logic               pop;
  logic [ENTRY_W-1:0] wr_entry;
  logic [ENTRY_W-1:0] rd_entry;

  tdpt_front #(
    .W (NUMBER_WIDTH)
  ) u_front (
    .start     (start),
    .in_number (in_number),
    .qstat     (qstat),
    .busy      (busy),
    .push      (push),
    .entry     (wr_entry)
  );

  tdpt_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (tdpt_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (wr_entry),
    .pop     (pop),
    .rd_data (rd_entry),
    .qstat   (qstat)
  );

  tdpt_back #(
    .W (NUMBER_WIDTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .entry             (rd_entry),
    .qstat             (qstat),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_is_prime      (out_is_prime),
    .out_tested_number (out_tested_number)
  );

endmodule

`default_nettype wire
